// ===== design/imu_angle_frame_parser_unit_macros.svh =====
// assertion helpers for the parser rtl
`ifndef IMU_ANGLE_FRAME_PARSER_UNIT_MACROS_SVH
`define IMU_ANGLE_FRAME_PARSER_UNIT_MACROS_SVH

// implication property checked on every rising clock edge outside reset
`define AFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same check, but for a plain condition that must hold at every edge
`define AFP_ASSERT_ALWAYS(lbl, cond, msg) \
  `AFP_ASSERT(lbl, 1'b1 |-> (cond), msg)

`endif

// ===== design/imu_afp_pkg.sv =====
`default_nettype none

package imu_afp_pkg;

  localparam logic [7:0]  FrameHeader   = 8'h55;
  localparam logic [7:0]  AngleType     = 8'h53;
  localparam logic [5:0]  LastPosition  = 6'd32;  // position of the checksum byte
  localparam logic [5:0]  PositionLimit = 6'd34;
  localparam logic [5:0]  SumFirst      = 6'd22;
  localparam logic [5:0]  SumLast       = 6'd31;
  localparam logic [5:0]  TypePosition  = 6'd23;
  localparam logic [5:0]  CaptureFirst  = 6'd24;
  localparam int unsigned CaptureCount  = 6;
  localparam logic [15:0] HalfTurnQ7    = 16'd23040;

  typedef struct packed {
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic        updated;
    logic        valid;
  } result_t;

  // floor((raw + 32768) * 45 / 64), raw taken as a signed little-endian word
  function automatic logic [15:0] scale_angle(logic [7:0] lo, logic [7:0] hi);
    logic [21:0] biased;
    logic [21:0] prod;
    biased = {6'd0, ({hi, lo} ^ 16'h8000)};
    prod   = (biased << 5) + (biased << 3) + (biased << 2) + biased;
    return prod[21:6];
  endfunction

endpackage

`default_nettype wire

// ===== design/imu_angle_frame_parser_unit.sv =====
// imu angle frame parser
// slave channel: one received serial byte per beat in s_axis_tdata_i, with
// s_axis_tlast_i marking the last byte of a burst. a 33-byte burst whose
// first byte is 0x55 and whose last byte equals the mod-256 sum of bytes
// 22..31 is a valid frame; with type byte 0x53 the roll, pitch and yaw words
// in bytes 24..29 are scaled to q9.7 degrees (signed; yaw unsigned, wrapped 0..360).
// master channel: one result beat per tlast byte, none for other bytes.
// tuser carries the valid and updated flags, tdata the stored angles.
// the result beat is registered from its tlast byte, into the result register if
// that is free, else into the skid register. throughput: one byte per cycle while
// s_axis_tready_o is high; all the per-byte work (position counter, checksum adder,
// captures, three shift-add scalers) sits between state and result registers.
// the result register is backed by a one-beat skid register, so bytes keep
// flowing while a result waits; s_axis_tready_o drops only when both hold a
// beat, i.e. after two unread results.
// reset clears the position counter, the checksum, the stored angles (to zero) and
// empties the result path; no result is pending after reset.
`default_nettype none

module imu_angle_frame_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic        s_axis_tlast_i,   // end_of_frame
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [47:0] m_axis_tdata_o,   // [15:0] roll_angle, [31:16] pitch_angle,
                                             // [47:32] yaw_angle
  output      logic [1:0]  m_axis_tuser_o    // [0] frame_valid, [1] angles_updated
);

  // parser state
  logic [5:0]  pos_q, pos_d;
  logic        header_q, header_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  cap_q [imu_afp_pkg::CaptureCount];
  logic [15:0] roll_q, roll_d;
  logic [15:0] pitch_q, pitch_d;
  logic [15:0] yaw_q, yaw_d;

  // result path: output register plus skid register
  imu_afp_pkg::result_t out_q, skid_q, res;
  logic out_valid_q, skid_valid_q;

  logic        accept;
  logic        produce;
  logic        out_free;
  logic [7:0]  b;
  logic        frame_ok;
  logic        in_capture;
  logic [2:0]  cap_off;
  logic [15:0] roll_s, pitch_s, yaw_s;

  assign b        = s_axis_tdata_i;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign produce  = accept && s_axis_tlast_i;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign in_capture = (pos_q >= imu_afp_pkg::CaptureFirst) &&
                      (pos_q < imu_afp_pkg::CaptureFirst + 6'(imu_afp_pkg::CaptureCount));
  assign cap_off    = 3'(pos_q - imu_afp_pkg::CaptureFirst);

  // scaled magnitudes, offset by half a turn
  assign roll_s  = imu_afp_pkg::scale_angle(cap_q[0], cap_q[1]);
  assign pitch_s = imu_afp_pkg::scale_angle(cap_q[2], cap_q[3]);
  assign yaw_s   = imu_afp_pkg::scale_angle(cap_q[4], cap_q[5]);

  always_comb begin
    pos_d    = pos_q;
    header_d = header_q;
    sum_d    = sum_q;
    type_d   = type_q;
    roll_d   = roll_q;
    pitch_d  = pitch_q;
    yaw_d    = yaw_q;
    frame_ok = 1'b0;
    if (accept) begin
      if (pos_q == 6'd0) begin
        header_d = (b == imu_afp_pkg::FrameHeader);
      end
      if (pos_q >= imu_afp_pkg::SumFirst && pos_q <= imu_afp_pkg::SumLast) begin
        sum_d = sum_q + b;
      end
      if (pos_q == imu_afp_pkg::TypePosition) begin
        type_d = b;
      end
      if (pos_q < imu_afp_pkg::PositionLimit) begin
        pos_d = pos_q + 6'd1;
      end
      if (s_axis_tlast_i) begin
        frame_ok = (pos_q == imu_afp_pkg::LastPosition) && header_d && (b == sum_d);
        if (frame_ok && type_d == imu_afp_pkg::AngleType) begin
          roll_d  = roll_s - imu_afp_pkg::HalfTurnQ7;
          pitch_d = pitch_s - imu_afp_pkg::HalfTurnQ7;
          // negative yaw wraps by a full turn
          yaw_d   = (yaw_s >= imu_afp_pkg::HalfTurnQ7) ? yaw_s - imu_afp_pkg::HalfTurnQ7
                                                       : yaw_s + imu_afp_pkg::HalfTurnQ7;
        end
        pos_d = 6'd0;
        sum_d = 8'd0;
      end
    end
  end

  always_comb begin
    res.valid   = frame_ok;
    res.updated = frame_ok && (type_d == imu_afp_pkg::AngleType);
    res.roll    = roll_d;
    res.pitch   = pitch_d;
    res.yaw     = yaw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      header_q <= 1'b0;
      sum_q    <= '0;
      type_q   <= '0;
      roll_q   <= '0;
      pitch_q  <= '0;
      yaw_q    <= '0;
    end else begin
      pos_q    <= pos_d;
      header_q <= header_d;
      sum_q    <= sum_d;
      type_q   <= type_d;
      roll_q   <= roll_d;
      pitch_q  <= pitch_d;
      yaw_q    <= yaw_d;
    end
  end

  // captured payload bytes, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && in_capture) begin
      cap_q[cap_off] <= b;
    end
  end

  // skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= produce;
      end else begin
        out_valid_q  <= produce;
      end
    end else if (produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (produce) begin
          skid_q <= res;
        end
      end else if (produce) begin
        out_q <= res;
      end
    end else if (produce) begin
      skid_q <= res;
    end
  end

  assign s_axis_tready_o = !skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.yaw, out_q.pitch, out_q.roll};
  assign m_axis_tuser_o  = {out_q.updated, out_q.valid};

  `include "imu_angle_frame_parser_unit_macros.svh"

  `AFP_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid full while out empty")
  `AFP_ASSERT_ALWAYS(a_pos_bound, pos_q <= imu_afp_pkg::PositionLimit, "position past limit")
  `AFP_ASSERT(a_updated_needs_valid, out_valid_q && out_q.updated |-> out_q.valid, "update w/o valid")
  `AFP_ASSERT(a_angles_hold, !produce |=> $stable(roll_q) && $stable(yaw_q), "angles moved")
  `AFP_ASSERT(a_tlast_restarts, produce |=> pos_q == 6'd0 && sum_q == 8'd0, "no restart")

endmodule

`default_nettype wire
